// ===== design/idr_pkg.sv =====
// Package: shared constants and helpers for the binary64 remainder block.
package idr_pkg;
    localparam int QBITS_DEFAULT = 2;
    localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEF_NAN   = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] EXP_MAX   = 11'h7FF;

    typedef struct packed {
        logic load;
        logic step;
        logic fix;
        logic norm;
        logic done;
    } idr_cmd_t;

    typedef struct packed {
        logic special;
        logic div_last;
        logic norm_done;
    } idr_sts_t;

    // Exact binary32 -> binary64 widening; subnormal normalized by leading-zero count.
    function automatic logic [63:0] widen_single(input logic [31:0] b);
        logic        s;
        logic [7:0]  e8;
        logic [22:0] f;
        logic [4:0]  lz;
        logic [52:0] m;
        logic [10:0] e;
        s  = b[31];
        e8 = b[30:23];
        f  = b[22:0];
        lz = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (f[i])
            begin
                lz = 5'(22 - i);
            end
        end
        if (e8 == 8'hFF)
        begin
            widen_single = {s, EXP_MAX, f, 29'd0};
        end
        else if (e8 == 8'd0)
        begin
            if (f == 23'd0)
            begin
                widen_single = {s, 63'd0};
            end
            else
            begin
                m = {30'd0, f} << (6'd30 + 6'(lz));
                e = 11'd896 - 11'(lz);
                widen_single = {s, e, m[51:0]};
            end
        end
        else
        begin
            widen_single = {s, (e8[7] ? 4'b1000 : 4'b0111), e8[6:0], f, 29'd0};
        end
    endfunction
endpackage

// ===== design/idr_ctrl.sv =====
// Controller: sequences load, long division, rounding fix and normalization.
module idr_ctrl
    import idr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  idr_sts_t sts,
    output idr_cmd_t cmd,
    output logic     busy
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.special)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (sts.div_last)
                    begin
                        state_next = S_FIX;
                    end
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (sts.norm_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.norm = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.done   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

// ===== design/idr_dp.sv =====
// Datapath: operand decode, restoring division, rounding and normalization.
module idr_dp
    import idr_pkg::*;
#(
    parameter int QBITS = QBITS_DEFAULT
)
(
    input  logic        clk,
    input  idr_cmd_t    cmd,
    input  logic [63:0] x_bits,
    input  logic        x_single,
    input  logic [63:0] y_bits,
    input  logic        y_single,
    output idr_sts_t    sts,
    output logic [63:0] result_bits,
    output logic        invalid
);
    logic [63:0] xb, yb;
    logic [10:0] xe, ye, ex, ey;
    logic [51:0] xf, yf;
    logic        xnan, ynan;

    logic [54:0] r_reg, r_next;
    logic [53:0] b_reg, b_next;
    logic [52:0] q_reg, q_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [10:0] e_reg, e_next;
    logic        odd_reg, odd_next;
    logic        sign_reg, sign_next;
    logic        xs_reg;
    logic        spec_reg, spec_next;
    logic [63:0] res_reg, res_next;
    logic        inv_reg, inv_next;

    assign xb = x_single ? widen_single(x_bits[31:0]) : x_bits;
    assign yb = y_single ? widen_single(y_bits[31:0]) : y_bits;
    assign xe = xb[62:52];
    assign ye = yb[62:52];
    assign xf = xb[51:0];
    assign yf = yb[51:0];
    assign xnan = (xe == EXP_MAX) && (xf != 52'd0);
    assign ynan = (ye == EXP_MAX) && (yf != 52'd0);
    assign ex = (xe == 11'd0) ? 11'd1 : xe;
    assign ey = (ye == 11'd0) ? 11'd1 : ye;

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        b_reg    <= b_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        e_reg    <= e_next;
        odd_reg  <= odd_next;
        sign_reg <= sign_next;
        spec_reg <= spec_next;
        res_reg  <= res_next;
        inv_reg  <= inv_next;
        if (cmd.load)
        begin
            xs_reg <= xb[63];
        end
    end

    always_comb
    begin
        logic [55:0] rr;
        logic [54:0] r2;
        logic [63:0] n;
        r_next    = r_reg;
        b_next    = b_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        e_next    = e_reg;
        odd_next  = odd_reg;
        sign_next = sign_reg;
        spec_next = spec_reg;
        res_next  = res_reg;
        inv_next  = inv_reg;
        rr        = '0;
        r2        = '0;
        n         = '0;
        if (cmd.load)
        begin
            spec_next = 1'b1;
            inv_next  = 1'b0;
            res_next  = xb;
            odd_next  = 1'b0;
            sign_next = xb[63];
            if (xnan || ynan)
            begin
                n        = xnan ? xb : yb;
                res_next = n | QUIET_BIT;
                inv_next = ((n & QUIET_BIT) == 64'd0);
            end
            else if (xe == EXP_MAX || (ye == 11'd0 && yf == 52'd0))
            begin
                res_next = DEF_NAN;
                inv_next = 1'b1;
            end
            else if (ye == EXP_MAX || (xe == 11'd0 && xf == 52'd0))
            begin
                res_next = xb;
            end
            else if (ex >= ey)
            begin
                spec_next = 1'b0;
                b_next    = {1'b0, (ye != 11'd0), yf};
                r_next    = 55'd0;
                q_next    = {(xe != 11'd0), xf};
                // shift in 53 dividend bits then ex-ey zero bits
                cnt_next  = 12'(ex - ey) + 12'd53;
                e_next    = ey;
            end
            else if (ex + 11'd1 == ey)
            begin
                spec_next = 1'b0;
                b_next    = {(ye != 11'd0), yf, 1'b0};
                r_next    = {2'd0, (xe != 11'd0), xf};
                cnt_next  = 12'd0;
                e_next    = ex;
            end
        end
        else if (cmd.step)
        begin
            for (int k = 0; k < QBITS; k++)
            begin
                if (cnt_next != 12'd0)
                begin
                    rr     = {r_next, q_next[52]};
                    q_next = {q_next[51:0], 1'b0};
                    r_next = rr[54:0];
                    if (r_next >= {1'b0, b_next})
                    begin
                        r_next   = r_next - {1'b0, b_next};
                        odd_next = 1'b1;
                    end
                    else
                    begin
                        odd_next = 1'b0;
                    end
                    cnt_next = cnt_next - 12'd1;
                end
            end
        end
        else if (cmd.fix)
        begin
            r2 = {r_reg[53:0], 1'b0};
            if (r2 > {1'b0, b_reg} || (r2 == {1'b0, b_reg} && odd_reg))
            begin
                r_next    = {1'b0, b_reg} - r_reg;
                sign_next = ~sign_reg;
            end
        end
        else if (cmd.norm)
        begin
            r_next = {r_reg[53:0], 1'b0};
            e_next = e_reg - 11'd1;
        end
        else if (cmd.done && !spec_reg)
        begin
            if (r_reg == 55'd0)
            begin
                res_next = {xs_reg, 63'd0};
            end
            else if (r_reg[52])
            begin
                res_next = {sign_reg, e_reg, r_reg[51:0]};
            end
            else
            begin
                res_next = {sign_reg, 11'd0, r_reg[51:0]};
            end
        end
    end

    assign sts.special   = spec_reg;
    assign sts.div_last  = (cnt_reg <= 12'(QBITS));
    assign sts.norm_done = (r_reg == 55'd0) || r_reg[52] || (e_reg <= 11'd1);
    assign result_bits   = res_reg;
    assign invalid       = inv_reg;
endmodule

// ===== design/ieee_double_remainder_top.sv =====
// Top level: IEEE 754 binary64 remainder with binary32 operand widening.
// Usage:
//   Pulse start with x_bits/x_single/y_bits/y_single while busy is low;
//   the request is taken at that edge and busy rises next cycle.
//   When done, result_bits and invalid are presented with strobe high for
//   exactly one cycle; the receiver cannot stall and must take it then.
// Sequence:
//   Special operands (NaN, infinity, zero, tiny x) skip the division steps,
//   the rounding fix and normalization. Otherwise the restoring divider retires
//   QUOTIENT_BITS_PER_CYCLE quotient bits each cycle over the 53 dividend
//   bits and ex - ey further zero bits when ex >= ey (no quotient bits when
//   ey = ex + 1), then a rounding fix, then normalization left shifts until
//   the leading bit is set or the exponent reaches its minimum.
// Throughput: one request at a time; busy stays high until the strobe.
// Reset: rst_n asynchronous active low; returns to idle, no result pending.
module ieee_double_remainder_top
    import idr_pkg::*;
#(
    parameter int QUOTIENT_BITS_PER_CYCLE = QBITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] x_bits,
    input  logic        x_single,
    input  logic [63:0] y_bits,
    input  logic        y_single,
    output logic        strobe,
    output logic [63:0] result_bits,
    output logic        invalid
);
    idr_cmd_t cmd;
    idr_sts_t sts;

    idr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    idr_dp #(.QBITS(QUOTIENT_BITS_PER_CYCLE)) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .x_bits      (x_bits),
        .x_single    (x_single),
        .y_bits      (y_bits),
        .y_single    (y_single),
        .sts         (sts),
        .result_bits (result_bits),
        .invalid     (invalid)
    );

    logic strobe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.done;
        end
    end

    assign strobe = strobe_reg;

`ifndef NO_ASSERTIONS
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy)) else $error("strobe without request");
    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe) else $error("double strobe");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy) else $error("load while busy");
`endif
endmodule
